// ===== src/tree_diameter_double_walk_macros.svh =====
// Assertion macros for the tree diameter block.
`ifndef TREE_DIAMETER_DOUBLE_WALK_MACROS_SVH
`define TREE_DIAMETER_DOUBLE_WALK_MACROS_SVH

// Check on every clock edge outside reset.
`define TDDW_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define TDDW_CHECK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tddw_pkg.sv =====
// Types and constants shared by the tree diameter block.
`timescale 1ns / 1ps
`default_nettype none
package tddw_pkg;

  localparam int unsigned FIELD_W = 11;

  typedef struct packed {
    logic [FIELD_W-1:0] end_a;
    logic [FIELD_W-1:0] end_b;
    logic               edge_present;
    logic               last_item;
  } tddw_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] longest_path_nodes;
    logic               bad_edge;
  } tddw_out_t;

  typedef struct packed {
    logic busy;
    logic clearing;
  } tddw_stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_W_INIT,
    ST_W_START,
    ST_W_TOP,
    ST_W_SLOT,
    ST_W_NODE,
    ST_W_POP,
    ST_RESULT
  } tddw_state_t;

endpackage
`default_nettype wire

// ===== src/tddw_ram.sv =====
// Generic synchronous RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps
`default_nettype none
module tddw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/tddw_core.sv =====
// Edge loader, two depth-first walks and list clearing over three memories.
`timescale 1ns / 1ps
`default_nettype none
module tddw_core
  import tddw_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             accept,
  input  wire tddw_in_t                         in_word,
  input  wire logic [$clog2(MAX_NODES+1)-1:0]   n_eff,
  output logic                                  res_valid,
  output tddw_out_t                             res_word,
  output tddw_stat_t                            stat
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned SC = 2 * (MAX_NODES - 1);
  localparam int unsigned SW = $clog2(SC);
  localparam int unsigned LW = $clog2(SC + 1);
  localparam int unsigned DW = $clog2(MAX_NODES + 1);
  localparam int unsigned XW = (DW > FIELD_W) ? DW : FIELD_W;

  tddw_state_t   state_r, state_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [AW-1:0] a_idx_r, a_idx_nxt;
  logic [AW-1:0] b_idx_r, b_idx_nxt;
  logic          self_r, self_nxt;
  logic          last_r, last_nxt;
  logic [LW-1:0] slots_r, slots_nxt;
  logic          err_r, err_nxt;
  logic          walk2_r, walk2_nxt;
  logic [LW-1:0] top_link_r, top_link_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] best_r, best_nxt;
  logic [AW-1:0] far_r, far_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt;

  // node memory word: {visited, list head link}
  logic             node_we;
  logic [AW-1:0]    node_waddr, node_raddr;
  logic [LW:0]      node_wdata, node_rdata;
  // slot memory word: {target index, next link}
  logic             slot_we;
  logic [SW-1:0]    slot_waddr, slot_raddr;
  logic [AW+LW-1:0] slot_wdata, slot_rdata;
  // stack memory: links of the entries below the top
  logic             stk_we;
  logic [AW-1:0]    stk_waddr, stk_raddr;
  logic [LW-1:0]    stk_wdata, stk_rdata;

  logic [XW-1:0]    a_x, b_x, n_x;
  logic [LW:0]      slots_plus2;
  logic             range_bad;
  logic             nd_vis;
  logic [LW-1:0]    nd_head;
  logic [LW-1:0]    head_b;
  logic             mark;
  logic [AW-1:0]    start_idx;

  tddw_ram #(.WIDTH(LW + 1), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  tddw_ram #(.WIDTH(AW + LW), .DEPTH(SC)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  tddw_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign a_x         = XW'(in_word.end_a);
  assign b_x         = XW'(in_word.end_b);
  assign n_x         = XW'(n_eff);
  assign slots_plus2 = {1'b0, slots_r} + (LW + 1)'(2);
  assign range_bad   = (a_x == '0) || (b_x == '0) || (a_x > n_x) || (b_x > n_x) ||
                       (slots_plus2 > (LW + 1)'(SC));
  assign nd_vis      = node_rdata[LW];
  assign nd_head     = node_rdata[LW-1:0];
  // a self loop reads its own list head before the first write lands
  assign head_b      = self_r ? slots_r : nd_head;
  // first walk marks visited with one, second walk clears the marks back
  assign mark        = !walk2_r;
  assign start_idx   = walk2_r ? far_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_idx_r <= '0;
      slots_r <= '0;
      err_r <= 1'b0;
      walk2_r <= 1'b0;
      last_r <= 1'b0;
      depth_r <= '0;
      best_r <= '0;
      far_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      slots_r <= slots_nxt;
      err_r <= err_nxt;
      walk2_r <= walk2_nxt;
      last_r <= last_nxt;
      depth_r <= depth_nxt;
      best_r <= best_nxt;
      far_r <= far_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_idx_r <= a_idx_nxt;
    b_idx_r <= b_idx_nxt;
    self_r <= self_nxt;
    top_link_r <= top_link_nxt;
    tgt_r <= tgt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    clr_idx_nxt = clr_idx_r;
    a_idx_nxt = a_idx_r;
    b_idx_nxt = b_idx_r;
    self_nxt = self_r;
    last_nxt = last_r;
    slots_nxt = slots_r;
    err_nxt = err_r;
    walk2_nxt = walk2_r;
    top_link_nxt = top_link_r;
    depth_nxt = depth_r;
    best_nxt = best_r;
    far_nxt = far_r;
    tgt_nxt = tgt_r;
    node_we = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;
    slot_we = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    slot_raddr = '0;
    stk_we = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_raddr = '0;
    res_valid = 1'b0;
    res_word.longest_path_nodes = FIELD_W'(best_r);
    res_word.bad_edge = err_r;

    case (state_r)
      ST_CLEAR: begin
        node_we = 1'b1;
        node_waddr = clr_idx_r;
        if (clr_idx_r == AW'(MAX_NODES - 1)) begin
          clr_idx_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          a_idx_nxt = AW'(a_x - XW'(1));
          b_idx_nxt = AW'(b_x - XW'(1));
          self_nxt = (in_word.end_a == in_word.end_b);
          last_nxt = in_word.last_item;
          node_raddr = AW'(a_x - XW'(1));
          if (in_word.edge_present && !range_bad) begin
            state_nxt = ST_LOAD_A;
          end else begin
            if (in_word.edge_present) begin
              err_nxt = 1'b1;
            end
            if (in_word.last_item) begin
              walk2_nxt = 1'b0;
              state_nxt = ST_W_INIT;
            end
          end
        end
      end
      ST_LOAD_A: begin
        slot_we = 1'b1;
        slot_waddr = SW'(slots_r);
        slot_wdata = {b_idx_r, nd_head};
        node_we = 1'b1;
        node_waddr = a_idx_r;
        node_wdata = {1'b0, slots_r + LW'(1)};
        node_raddr = b_idx_r;
        slots_nxt = slots_r + LW'(1);
        state_nxt = ST_LOAD_B;
      end
      ST_LOAD_B: begin
        slot_we = 1'b1;
        slot_waddr = SW'(slots_r);
        slot_wdata = {a_idx_r, head_b};
        node_we = 1'b1;
        node_waddr = b_idx_r;
        node_wdata = {1'b0, slots_r + LW'(1)};
        slots_nxt = slots_r + LW'(1);
        if (last_r) begin
          walk2_nxt = 1'b0;
          state_nxt = ST_W_INIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_W_INIT: begin
        node_raddr = start_idx;
        state_nxt = ST_W_START;
      end
      ST_W_START: begin
        node_we = 1'b1;
        node_waddr = start_idx;
        node_wdata = {mark, nd_head};
        top_link_nxt = nd_head;
        depth_nxt = DW'(1);
        best_nxt = DW'(1);
        far_nxt = start_idx;
        state_nxt = ST_W_TOP;
      end
      ST_W_TOP: begin
        if (top_link_r == '0) begin
          // list exhausted: drop the top entry
          depth_nxt = depth_r - DW'(1);
          if (depth_r == DW'(1)) begin
            if (walk2_r) begin
              state_nxt = ST_RESULT;
            end else begin
              walk2_nxt = 1'b1;
              state_nxt = ST_W_INIT;
            end
          end else begin
            stk_raddr = AW'(depth_r - DW'(2));
            state_nxt = ST_W_POP;
          end
        end else begin
          slot_raddr = SW'(top_link_r - LW'(1));
          state_nxt = ST_W_SLOT;
        end
      end
      ST_W_POP: begin
        top_link_nxt = stk_rdata;
        state_nxt = ST_W_TOP;
      end
      ST_W_SLOT: begin
        top_link_nxt = slot_rdata[LW-1:0];
        tgt_nxt = slot_rdata[AW+LW-1:LW];
        node_raddr = slot_rdata[AW+LW-1:LW];
        state_nxt = ST_W_NODE;
      end
      ST_W_NODE: begin
        state_nxt = ST_W_TOP;
        if (nd_vis != mark) begin
          node_we = 1'b1;
          node_waddr = tgt_r;
          node_wdata = {mark, nd_head};
          if (depth_r < DW'(MAX_NODES)) begin
            // push the advanced top, descend into the new node
            stk_we = 1'b1;
            stk_waddr = AW'(depth_r - DW'(1));
            stk_wdata = top_link_r;
            top_link_nxt = nd_head;
            depth_nxt = depth_r + DW'(1);
            if ((depth_r + DW'(1)) > best_r) begin
              best_nxt = depth_r + DW'(1);
              far_nxt = tgt_r;
            end
          end
        end
      end
      ST_RESULT: begin
        res_valid = 1'b1;
        slots_nxt = '0;
        err_nxt = 1'b0;
        clr_idx_nxt = '0;
        state_nxt = ST_CLEAR;
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_idx_nxt = '0;
      end
    endcase
  end

  assign stat.busy     = (state_r != ST_IDLE);
  assign stat.clearing = (state_r == ST_CLEAR);

endmodule
`default_nettype wire

// ===== src/tree_diameter_double_walk.sv =====
// Top level of the tree diameter block: configuration, result register, checks.
`timescale 1ns / 1ps
`default_nettype none
// Loads a tree one edge word at a time and, on the word marked last, returns the
// number of nodes on its longest path plus a flag for any edge that was dropped
// (end out of range or edge memory full). An edge word is loaded in steps set by
// the single write port of the node memory (read list head of one end, link it
// and read the other end, link that). Each of the two depth-first walks reads
// its start node, marks it, then follows each adjacency slot (stack top, slot
// read, node read) and leaves each node through stack top and a pop (the start
// node through stack top alone). The result is held one cycle on out_valid
// and must be taken then: the receiver cannot stall. Right after reset and
// after each result the block sweeps all MAX_NODES entries of the node memory
// with busy high; configuration writes are taken at any time.
`include "tree_diameter_double_walk_macros.svh"
module tree_diameter_double_walk
  import tddw_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire tddw_in_t           in_word,
  output logic                    out_valid,
  output tddw_out_t               out_word,
  input  wire logic               cfg_we,
  input  wire logic [FIELD_W-1:0] cfg_wdata
);

  localparam int unsigned DW = $clog2(MAX_NODES + 1);
  localparam int unsigned XW = (DW > FIELD_W) ? DW : FIELD_W;

  logic [FIELD_W-1:0] node_count_r, node_count_nxt;
  logic               out_valid_r, out_valid_nxt;
  tddw_out_t          out_word_r;
  logic [XW-1:0]      nc_x;
  logic [DW-1:0]      n_eff;
  logic               res_valid;
  tddw_out_t          res_word;
  tddw_stat_t         core_stat;

  // zero counts as one node, anything above the memory size is clipped
  always_comb begin
    nc_x = XW'(node_count_r);
    if (nc_x == '0) begin
      n_eff = DW'(1);
    end else if (nc_x > XW'(MAX_NODES)) begin
      n_eff = DW'(MAX_NODES);
    end else begin
      n_eff = DW'(nc_x);
    end
  end

  assign node_count_nxt = cfg_we ? cfg_wdata : node_count_r;
  assign out_valid_nxt  = res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= FIELD_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      node_count_r <= node_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word_r <= res_word;
    end
  end

  tddw_core #(.MAX_NODES(MAX_NODES)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (start && !busy),
    .in_word   (in_word),
    .n_eff     (n_eff),
    .res_valid (res_valid),
    .res_word  (res_word),
    .stat      (core_stat)
  );

  assign busy      = core_stat.busy;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `TDDW_CHECK_RST(a_reset_clears, !rst_n |=> core_stat.clearing, "no clearing pass after reset")
  `TDDW_CHECK(a_result_then_clear, out_valid |-> core_stat.clearing, "result without list clearing")
  `TDDW_CHECK(a_empty_word_idle, start && !busy && !in_word.edge_present && !in_word.last_item |=> !busy, "empty word left block busy")

endmodule
`default_nettype wire
